// File: sv/qsu_pkg.sv
// ----------------------------------------------------------------------------
// Quoted string unescaper package
// Shared types, codes and the hex digit decoder for the unescaper block.
// ----------------------------------------------------------------------------
package qsu_pkg;

  // Longest count of bytes that is reported; the byte counter saturates here.
  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned CNT_W   = 11;

  // Characters the decoder looks for.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_SKIP = 2'd3
  } status_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OPEN      = 3'd1,
    ERR_BAD_ESC   = 3'd2,
    ERR_NOT_HEX   = 3'd3,
    ERR_HEX_ZERO  = 3'd4,
    ERR_HEX_SHORT = 3'd5,
    ERR_UNTERM    = 3'd6,
    ERR_RSVD      = 3'd7
  } err_t;

  // One input item.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic             data_valid;
    logic [7:0]       data_byte;
    status_t          status;
    err_t             error_code;
    logic [CNT_W-1:0] consumed;
  } result_t;

  // Hex digit decode: bit 4 flags a legal digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if (c inside {[CH_A:CH_F]}) begin
      d = c - CH_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// File: sv/quoted_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// Quoted string unescaper unit
// Unquotes a C-style escaped string, one byte per item, with error codes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | char_in, last_byte
//  out_    | output    | out_valid/out_stall| data_valid, data_byte, status,
//          |           |                    | error_code, consumed
//
//  Each item passes from acceptance through the input register, then
//  through the phase decoder into the result register.
//  One item is accepted every cycle while the result side keeps up.
//  A stall on the result side holds both registers; in_stall rises only
//  when the input register is full and cannot move on.
//  Reset is synchronous; the block then waits for an opening quote.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_unit import qsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_in,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_data_valid,
  output logic [7:0]       out_data_byte,
  output logic [1:0]       out_status,
  output logic [2:0]       out_error_code,
  output logic [CNT_W-1:0] out_consumed
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    adv;
  result_t res;

  assign in_item.char_in   = in_char_in;
  assign in_item.last_byte = in_last_byte;

  // Input register.
  qsu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Decoder with result register.
  qsu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_data_valid = res.data_valid;
  assign out_data_byte  = res.data_byte;
  assign out_status     = res.status;
  assign out_error_code = res.error_code;
  assign out_consumed   = res.consumed;

  // A decoded byte never comes with a finish or an error.
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_status == ST_BUSY && out_error_code == ERR_NONE))
    else $error("data byte reported with a non-busy status");

  // An error always carries a code, and only an error does.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_ERR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match status");

  // The count shows only on completion, and then covers both quotes.
  a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_DONE) ? (out_consumed >= CNT_W'(2))
                                           : (out_consumed == '0)))
    else $error("consumed count inconsistent with status");

  // The data byte is zero unless it is marked valid.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> (out_data_byte == 8'd0))
    else $error("stray data byte");

endmodule

// File: sv/qsu_in_stage.sv
// ----------------------------------------------------------------------------
// Quoted string unescaper input stage
// Registers each accepted item and hands it on when the core advances.
// ----------------------------------------------------------------------------
module qsu_in_stage import qsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  adv,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // The register takes a new item when it is empty or its item moves on.
  assign in_stall  = valid_r & ~adv;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: sv/qsu_core.sv
// ----------------------------------------------------------------------------
// Quoted string unescaper core
// Phase machine, byte counter and result register; one item per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module qsu_core import qsu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  item_t   s1_item,
  input  logic    out_stall,
  output logic    adv,
  output logic    out_valid,
  output result_t out_res
);

  typedef enum logic [2:0] {
    PH_OPEN = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             oval_r, oval_nxt;
  result_t          res_r, res_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [4:0]       hex;
  logic [7:0]       hval;
  logic [7:0]       c;
  logic             last;
  logic             step;

  // The result register is free when empty or being taken this cycle.
  assign adv  = ~oval_r | ~out_stall;
  assign step = s1_valid & adv;

  assign c       = s1_item.char_in;
  assign last    = s1_item.last_byte;
  assign cnt_inc = (cnt_r < CNT_W'(MAX_LEN)) ? cnt_r + 1'b1 : cnt_r;
  assign hex     = hex_decode(c);
  assign hval    = {nib_r, hex[3:0]};

  // Decode one byte against the current phase.
  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    cnt_nxt   = cnt_r;
    res_nxt   = '0;
    res_nxt.status     = ST_BUSY;
    res_nxt.error_code = ERR_NONE;
    case (phase_r)
      PH_OPEN: begin
        cnt_nxt = '0;
        nib_nxt = 4'd0;
        if (c != CH_QUOTE || last) begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_OPEN;
        end else begin
          cnt_nxt   = CNT_W'(1);
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        cnt_nxt = cnt_inc;
        if (c == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else if (c == CH_QUOTE) begin
          res_nxt.status   = ST_DONE;
          res_nxt.consumed = cnt_inc;
        end else begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = c;
        end
      end
      PH_ESC: begin
        cnt_nxt   = cnt_inc;
        phase_nxt = PH_BODY;
        if (c == CH_BSL || c == CH_QUOTE) begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = c;
        end else if (c == CH_N) begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = CH_LF;
        end else if (c == CH_R) begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = CH_CR;
        end else if (c == CH_T) begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = CH_TAB;
        end else if (c == CH_X) begin
          phase_nxt = PH_HEX1;
        end else begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_BAD_ESC;
        end
      end
      PH_HEX1: begin
        cnt_nxt = cnt_inc;
        if (last) begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_HEX_SHORT;
        end else if (!hex[4]) begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_NOT_HEX;
        end else begin
          nib_nxt   = hex[3:0];
          phase_nxt = PH_HEX2;
        end
      end
      PH_HEX2: begin
        cnt_nxt   = cnt_inc;
        phase_nxt = PH_BODY;
        if (!hex[4]) begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_NOT_HEX;
        end else if (hval == 8'd0) begin
          res_nxt.status     = ST_ERR;
          res_nxt.error_code = ERR_HEX_ZERO;
        end else begin
          res_nxt.data_valid = 1'b1;
          res_nxt.data_byte  = hval;
        end
      end
      default: begin
        res_nxt.status = ST_SKIP;
      end
    endcase

    // A buffer that ends mid-string is unterminated.
    if (res_nxt.status == ST_BUSY && last) begin
      res_nxt.status     = ST_ERR;
      res_nxt.error_code = ERR_UNTERM;
      res_nxt.data_valid = 1'b0;
      res_nxt.data_byte  = 8'd0;
    end

    // Pass over the rest after a finish, and rearm on the last byte.
    if (res_nxt.status == ST_ERR || res_nxt.status == ST_DONE) begin
      phase_nxt = PH_SKIP;
    end
    if (last) begin
      phase_nxt = PH_OPEN;
    end
    if (res_nxt.status != ST_BUSY && phase_nxt == PH_OPEN) begin
      nib_nxt = 4'd0;
    end
  end

  // Output valid follows the input stage whenever the core advances.
  assign oval_nxt = adv ? s1_valid : oval_r;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      nib_r   <= 4'd0;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        nib_r   <= nib_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_res   = res_r;

endmodule
